@@ hw/rtl/shtp_pkg.sv @@
// Shared constants and types for the symbol hash table probe.
// Used by shtp_hash and symbol_hash_table_probe; depends on nothing else.
`timescale 1ns / 1ps

package shtp_pkg;

    // Table geometry (slot count must be a power of two)
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int USED_BITS   = SLOT_BITS + 1;
    localparam int ENTRY_BITS  = 10;

    // Name and hash
    localparam int NAME_CHARS  = 8;
    localparam int NAME_BITS   = 64;
    localparam int HASH_BITS   = 15;
    localparam int CNT_BITS    = $clog2(NAME_CHARS + 1);

    // Operation codes
    localparam logic OP_FIND        = 1'b0;
    localparam logic OP_FIND_INSERT = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_FOUND    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_INSERTED = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    // Lookup sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } shtp_state_t;

    // Hash unit status toward the sequencer
    typedef struct packed {
        logic                 done;
        logic [HASH_BITS-1:0] hash;
    } shtp_hash_stat_t;

endpackage

@@ hw/rtl/shtp_hash.sv @@
// Iterative name hasher: trims a name at its first NUL and hashes one byte a cycle.
// Depends on shtp_pkg.
`timescale 1ns / 1ps

module shtp_hash import shtp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NAME_BITS-1:0]  name_in,
    output logic [NAME_BITS-1:0]  name_kept,
    output shtp_hash_stat_t       stat
);

    logic                 busy_reg;
    logic [NAME_BITS-1:0] shift_reg;
    logic [NAME_BITS-1:0] kept_reg;
    logic [HASH_BITS-1:0] hash_reg;
    logic [CNT_BITS-1:0]  cnt_reg;

    logic [NAME_BITS-1:0] kept_next;
    logic [7:0]           cur_byte;
    logic [HASH_BITS-1:0] hash_sum;
    logic                 stop;

    // Zero every byte from the first NUL on and beyond the name length
    always_comb begin
        logic alive;
        alive     = 1'b1;
        kept_next = '0;
        for (int i = 0; i < NAME_BITS / 8; i++) begin
            if (i >= NAME_CHARS || name_in[8*i +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            kept_next[8*i +: 8] = alive ? name_in[8*i +: 8] : 8'd0;
        end
    end

    // Double and add the current byte; stop at NUL or name length
    assign cur_byte = shift_reg[7:0];
    assign hash_sum = {hash_reg[HASH_BITS-2:0], 1'b0} + HASH_BITS'(cur_byte);
    assign stop     = busy_reg && (cur_byte == 8'd0 || cnt_reg == CNT_BITS'(NAME_CHARS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (stop) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= kept_next;
            kept_reg  <= kept_next;
            hash_reg  <= '0;
            cnt_reg   <= '0;
        end else if (busy_reg && !stop) begin
            shift_reg <= shift_reg >> 8;
            hash_reg  <= hash_sum;
            cnt_reg   <= cnt_reg + CNT_BITS'(1);
        end
    end

    assign name_kept = kept_reg;
    assign stat.done = stop;
    assign stat.hash = hash_reg;

endmodule

@@ hw/rtl/symbol_hash_table_probe.sv @@
// One lookup is in flight at a time: the hasher walks the name byte by byte, then each
// probed slot is read and checked in turn before the result is registered.
// Throughput is set by the byte-serial hasher and the single-port slot table read.
// Reset is synchronous, active low; afterwards a clearing pass over all TABLE_SLOTS (1024)
// slots empties the slot valid table, and s_ready stays low until it ends.
// Top level: probe sequencer, slot tables and result register; uses shtp_pkg, shtp_hash.
`timescale 1ns / 1ps

module symbol_hash_table_probe import shtp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_operation,
    input  logic [NAME_BITS-1:0]   s_symbol_name,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic [SLOT_BITS-1:0]   m_slot_index,
    output logic [ENTRY_BITS-1:0]  m_entry_number
);

    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(TABLE_SLOTS - 1);

    // Slot tables
    logic                          valid_mem [TABLE_SLOTS];
    logic [NAME_BITS+ENTRY_BITS-1:0] data_mem [TABLE_SLOTS];

    shtp_state_t            state_reg, state_next;
    logic [SLOT_BITS-1:0]   clr_addr_reg;
    logic                   op_reg;
    logic [SLOT_BITS-1:0]   pos_reg;
    logic [SLOT_BITS-1:0]   home_reg;
    logic [SLOT_BITS-1:0]   tries_reg;
    logic [USED_BITS-1:0]   used_reg;
    logic [ENTRY_BITS-1:0]  next_entry_reg;
    logic                   rd_valid_reg;
    logic [NAME_BITS+ENTRY_BITS-1:0] rd_word_reg;
    logic [1:0]             res_status_reg;
    logic [SLOT_BITS-1:0]   res_slot_reg;
    logic [ENTRY_BITS-1:0]  res_entry_reg;
    logic                   m_valid_reg;
    logic [1:0]             m_status_reg;
    logic [SLOT_BITS-1:0]   m_slot_reg;
    logic [ENTRY_BITS-1:0]  m_entry_reg;

    logic [NAME_BITS-1:0]   name_kept;
    shtp_hash_stat_t        hash_stat;
    logic                   s_xfer;
    logic                   out_free;
    logic [USED_BITS-1:0]   used_inc;
    logic                   hit;
    logic                   miss;
    logic                   full;
    logic                   last_try;
    logic                   vmem_we;
    logic [SLOT_BITS-1:0]   vmem_addr;
    logic                   vmem_wdata;
    logic                   dmem_we;

    shtp_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_xfer),
        .name_in   (s_symbol_name),
        .name_kept (name_kept),
        .stat      (hash_stat)
    );

    // Probe decisions
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign used_inc = used_reg + USED_BITS'(1);
    assign miss     = !rd_valid_reg;
    assign hit      = rd_valid_reg && rd_word_reg[NAME_BITS+ENTRY_BITS-1:ENTRY_BITS] == name_kept;
    assign full     = used_inc >= USED_BITS'(TABLE_SLOTS);
    assign last_try = tries_reg == SLOT_LAST;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_addr_reg == SLOT_LAST) state_next = ST_IDLE;
            ST_IDLE:  if (s_xfer) state_next = ST_HASH;
            ST_HASH:  if (hash_stat.done) state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (miss || hit || last_try) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Handshake and table write controls
    always_comb begin
        s_ready    = 1'b0;
        vmem_we    = 1'b0;
        vmem_addr  = pos_reg;
        vmem_wdata = 1'b1;
        dmem_we    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                vmem_we    = 1'b1;
                vmem_addr  = clr_addr_reg;
                vmem_wdata = 1'b0;
            end
            ST_IDLE:  s_ready = 1'b1;
            ST_CHECK: begin
                if (miss && !full && op_reg == OP_FIND_INSERT) begin
                    vmem_we = 1'b1;
                    dmem_we = 1'b1;
                end
            end
            ST_HASH, ST_READ, ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Slot tables: one write port, registered read at the probe position
    always_ff @(posedge aclk) begin
        if (vmem_we) begin
            valid_mem[vmem_addr] <= vmem_wdata;
        end
        if (dmem_we) begin
            data_mem[pos_reg] <= {name_kept, next_entry_reg};
        end
        rd_valid_reg <= valid_mem[pos_reg];
        rd_word_reg  <= data_mem[pos_reg];
    end

    // Control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            used_reg       <= '0;
            next_entry_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + SLOT_BITS'(1);
            end
            if (state_reg == ST_CHECK && miss) begin
                used_reg <= full ? USED_BITS'(TABLE_SLOTS) : used_inc;
            end
            if (dmem_we) begin
                next_entry_reg <= next_entry_reg + ENTRY_BITS'(1);
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Probe datapath and result
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg <= s_operation;
        end
        if (state_reg == ST_HASH && hash_stat.done) begin
            home_reg  <= hash_stat.hash[SLOT_BITS-1:0];
            pos_reg   <= hash_stat.hash[SLOT_BITS-1:0];
            tries_reg <= '0;
        end
        if (state_reg == ST_CHECK) begin
            res_slot_reg  <= pos_reg;
            res_entry_reg <= '0;
            priority if (miss) begin
                if (full) begin
                    res_status_reg <= STATUS_OVERFLOW;
                end else if (op_reg == OP_FIND_INSERT) begin
                    res_status_reg <= STATUS_INSERTED;
                    res_entry_reg  <= next_entry_reg;
                end else begin
                    res_status_reg <= STATUS_EMPTY;
                end
            end else if (hit) begin
                res_status_reg <= STATUS_FOUND;
                res_entry_reg  <= rd_word_reg[ENTRY_BITS-1:0];
            end else if (last_try) begin
                res_status_reg <= STATUS_OVERFLOW;
                res_slot_reg   <= home_reg;
            end else begin
                pos_reg   <= pos_reg + SLOT_BITS'(1);
                tries_reg <= tries_reg + SLOT_BITS'(1);
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_entry_reg  <= res_entry_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_index   = m_slot_reg;
    assign m_entry_number = m_entry_reg;

    // A transfer in starts the hasher on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> state_reg == ST_HASH)
        else $error("input transfer did not start hashing");

    // The used-slot count never passes the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= USED_BITS'(TABLE_SLOTS))
        else $error("used slot count beyond table size");

    // A new result appears only from the result state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside result state");

    // Entry number advances only on an insert
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(next_entry_reg) |-> $past(dmem_we))
        else $error("entry number moved without insert");

endmodule

@@ test/symbol_hash_table_probe_test.sv @@
// Self-checking bench for symbol_hash_table_probe: directed lookups, then random traffic.
// A scoreboard class predicts each lookup result; depends on shtp_pkg and the top level.
`timescale 1ns / 1ps

module symbol_hash_table_probe_test;
    import shtp_pkg::*;

    localparam int RANDOM_ITEMS = 1130;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_BITS-1:0]  slot;
        logic [ENTRY_BITS-1:0] entry;
    } probe_result_t;

    // Shadow copy of the slot table; predicts every lookup and checks results in order
    class probe_scoreboard;
        bit                    slot_used [TABLE_SLOTS];
        logic [NAME_BITS-1:0]  slot_key [TABLE_SLOTS];
        logic [ENTRY_BITS-1:0] slot_num [TABLE_SLOTS];
        int unsigned           used_count;
        logic [ENTRY_BITS-1:0] entry_counter;
        probe_result_t         pending_results [$];
        logic [NAME_BITS-1:0]  stored_names [$];
        int                    errors;

        function new();
            foreach (slot_used[k]) slot_used[k] = 1'b0;
            used_count    = 0;
            entry_counter = '0;
            errors        = 0;
        endfunction

        // Predict the result of one accepted lookup and update the shadow table
        function void note_input(logic op, logic [NAME_BITS-1:0] raw);
            logic [NAME_BITS-1:0] key;
            logic [HASH_BITS-1:0] acc;
            logic [7:0]           ch;
            int unsigned          home, pos, tries;
            int                   i;
            bit                   ended, hit, open_found;
            probe_result_t        res;

            // Hash the bytes up to the first NUL; drop everything after it
            key   = '0;
            acc   = '0;
            ended = 1'b0;
            for (i = 0; i < NAME_CHARS; i++) begin
                ch = raw[8*i +: 8];
                if (ch == 8'd0) ended = 1'b1;
                if (!ended) begin
                    acc          = (acc << 1) + HASH_BITS'(ch);
                    key[8*i +: 8] = ch;
                end
            end
            home = int'(acc) % TABLE_SLOTS;

            // Walk upward with wrap until the name or a free slot turns up
            pos        = home;
            hit        = 1'b0;
            open_found = 1'b0;
            for (tries = 0; tries < TABLE_SLOTS && !hit && !open_found; tries++) begin
                if (!slot_used[pos]) open_found = 1'b1;
                else if (slot_key[pos] == key) hit = 1'b1;
                else pos = (pos + 1) % TABLE_SLOTS;
            end

            res.entry = '0;
            if (hit) begin
                res.status = STATUS_FOUND;
                res.entry  = slot_num[pos];
            end else if (!open_found) begin
                pos        = home;
                res.status = STATUS_OVERFLOW;
            end else if (used_count + 1 >= TABLE_SLOTS) begin
                used_count = TABLE_SLOTS;
                res.status = STATUS_OVERFLOW;
            end else begin
                used_count++;
                if (op == OP_FIND_INSERT) begin
                    slot_used[pos] = 1'b1;
                    slot_key[pos]  = key;
                    slot_num[pos]  = entry_counter;
                    res.entry      = entry_counter;
                    entry_counter  = entry_counter + 1'b1;
                    res.status     = STATUS_INSERTED;
                    stored_names.push_back(key);
                end else begin
                    res.status = STATUS_EMPTY;
                end
            end
            res.slot = SLOT_BITS'(pos);
            pending_results.push_back(res);
        endfunction

        // Compare one result transfer against the oldest prediction
        function void check_result(logic [1:0] status, logic [SLOT_BITS-1:0] slot,
                                   logic [ENTRY_BITS-1:0] entry);
            probe_result_t exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d entry %0d",
                         $time, status, slot, entry);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (status !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
                errors++;
            end
            if (slot !== exp_res.slot) begin
                $display("%0t: slot_index expected %0d actual %0d", $time, exp_res.slot, slot);
                errors++;
            end
            if (entry !== exp_res.entry) begin
                $display("%0t: entry_number expected %0d actual %0d",
                         $time, exp_res.entry, entry);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_operation    = OP_FIND;
    logic [NAME_BITS-1:0]  s_symbol_name  = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [1:0]            m_status;
    logic [SLOT_BITS-1:0]  m_slot_index;
    logic [ENTRY_BITS-1:0] m_entry_number;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    probe_scoreboard sb = new();

    symbol_hash_table_probe u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_symbol_name  (s_symbol_name),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot_index   (m_slot_index),
        .m_entry_number (m_entry_number)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #80_000_000;
        $display("symbol_hash_table_probe_test NOT OK");
        $finish;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Record input transfers and check result transfers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_status, m_slot_index, m_entry_number);
            if (s_valid && s_ready) sb.note_input(s_operation, s_symbol_name);
        end
    end

    // Offer one lookup, with an optional idle gap first; hold it until the transfer
    task automatic put_symbol(input logic op, input logic [NAME_BITS-1:0] name);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_symbol_name <= name;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Build a clean name of 1 to NAME_CHARS nonzero bytes
    function automatic logic [NAME_BITS-1:0] fresh_name();
        logic [NAME_BITS-1:0] v;
        int                   len, i;
        v   = {$urandom, $urandom};
        len = $urandom_range(NAME_CHARS, 1);
        for (i = 0; i < NAME_CHARS; i++) begin
            if (i >= len) v[8*i +: 8] = 8'd0;
            else if (v[8*i +: 8] == 8'd0) v[8*i +: 8] = 8'($urandom_range(255, 1));
        end
        return v;
    endfunction

    // Sometimes fill the bytes after the first NUL with junk
    function automatic logic [NAME_BITS-1:0] add_tail(input logic [NAME_BITS-1:0] name);
        logic [NAME_BITS-1:0] junk;
        bit                   past_nul;
        int                   i;
        junk     = {$urandom, $urandom};
        past_nul = 1'b0;
        if ($urandom_range(3) != 0) return name;
        for (i = 0; i < NAME_CHARS; i++) begin
            if (past_nul) name[8*i +: 8] = junk[8*i +: 8];
            else if (name[8*i +: 8] == 8'd0) past_nul = 1'b1;
        end
        return name;
    endfunction

    initial begin : stimulus
        int                   phase, n, roll, hit_pct;
        logic                 op;
        logic [NAME_BITS-1:0] name;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty name, tails after NUL, high bytes, collisions with wrap
        put_symbol(OP_FIND,        64'h0);
        put_symbol(OP_FIND_INSERT, 64'h0);
        put_symbol(OP_FIND,        64'hFFEE_DDCC_BBAA_9900);
        put_symbol(OP_FIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        put_symbol(OP_FIND,        64'hFFFF_FFFF_FFFF_FFFF);
        put_symbol(OP_FIND_INSERT, 64'h0000_0000_0001_01FF);
        put_symbol(OP_FIND_INSERT, 64'h0000_0000_0001_03FE);
        put_symbol(OP_FIND_INSERT, 64'h0000_0000_0001_05FD);
        put_symbol(OP_FIND,        64'h0000_0000_0001_05FD);
        put_symbol(OP_FIND,        64'h0000_0000_0001_07FC);
        put_symbol(OP_FIND_INSERT, 64'hAB00_CDEF_0000_0043);
        put_symbol(OP_FIND,        64'h0000_0000_0000_0043);
        put_symbol(OP_FIND_INSERT, 64'h7700_0000_0000_0043);
        put_symbol(OP_FIND_INSERT, 64'h8080_8080_8080_8080);
        put_symbol(OP_FIND_INSERT, 64'h7F7F_7F7F_7F7F_7F7F);
        put_symbol(OP_FIND,        64'h8080_8080_8080_8080);
        put_symbol(OP_FIND,        64'h0000_0000_0000_0001);
        put_symbol(OP_FIND_INSERT, 64'h0000_0000_0000_0001);
        put_symbol(OP_FIND,        64'h0000_0000_0001_07FC);
        put_symbol(OP_FIND,        64'h0000_0000_0001_01FF);

        // Random: mostly new names until the table overflows, then more repeats
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
                roll    = $urandom_range(99);
                hit_pct = (sb.used_count >= TABLE_SLOTS) ? 40 : 4;
                op      = 1'($urandom_range(1));
                if (roll < 4) begin
                    name = {$urandom, $urandom};
                end else if (roll < 4 + hit_pct && sb.stored_names.size() > 0) begin
                    name = add_tail(sb.stored_names[$urandom_range(sb.stored_names.size() - 1)]);
                end else begin
                    name = add_tail(fresh_name());
                    op   = ($urandom_range(99) < 45) ? OP_FIND_INSERT : OP_FIND;
                end
                put_symbol(op, name);
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("symbol_hash_table_probe_test OK");
        end else begin
            $display("symbol_hash_table_probe_test NOT OK");
        end
        $finish;
    end

endmodule
